// ===== src/lplt_pkg.sv =====
// ----------------------------------------------------------------------------
// lplt_pkg
// shared constants and controller/datapath interface types for the tracker
// ----------------------------------------------------------------------------
package lplt_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned BASE_RESET      = 1250;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic sample_en;
    logic report_load;
    logic div_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

// ===== src/lplt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lplt_ctrl
// sequencer: takes words, runs the serial division of a report, hands the
// result to the output register
// ----------------------------------------------------------------------------
module lplt_ctrl #(
  parameter int unsigned SUM_BITS = lplt_pkg::SAMPLE_BITS_DEF + lplt_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            req_type_i,
  output logic            in_stall_o,
  input  lplt_pkg::sts_t  sts_i,
  output lplt_pkg::cmd_t  cmd_o
);

  localparam int unsigned StepBits = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;
  localparam logic [StepBits-1:0] LastStep = StepBits'(SUM_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [StepBits-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == lplt_pkg::REQ_REPORT) begin
            cmd_o.report_load = 1'b1;
            step_d            = '0;
            state_d           = ST_DIVIDE;
          end else begin
            cmd_o.sample_en = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_blocked) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== src/lplt_datapath.sv =====
// ----------------------------------------------------------------------------
// lplt_datapath
// level registers, peak accumulators, two serial dividers and output register
// ----------------------------------------------------------------------------
module lplt_datapath #(
  parameter int unsigned SAMPLE_BITS = lplt_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = lplt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  lplt_pkg::cmd_t                cmd_i,
  output lplt_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS:0]   avg_high_offset_o,
  output logic signed [SAMPLE_BITS:0]   max_offset_o,
  output logic signed [SAMPLE_BITS:0]   min_offset_o,
  output logic signed [SAMPLE_BITS:0]   avg_low_offset_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned SW = SAMPLE_BITS + COUNT_BITS;

  logic [SB-1:0] base_q;
  logic [SB-1:0] max_q, min_q, last_q, older_q;
  logic [SW-1:0] hsum_q, lsum_q;
  logic [CB-1:0] hcnt_q, lcnt_q;

  logic [SB-1:0] max_d, min_d;
  logic          hpeak, lpeak;

  // divider state
  logic [SW-1:0] hq_q, lq_q, hq_d, lq_d;
  logic [CB-1:0] hr_q, lr_q, hr_d, lr_d;
  logic [CB-1:0] hc_q, lc_q;
  logic [CB:0]   hsh, lsh;
  logic          hge, lge;

  // max/min offsets held while dividing
  logic [SB:0]   maxo_q, mino_q;

  logic          out_valid_q;
  logic [SB:0]   oah_q, omax_q, omin_q, oal_q;
  logic [SB-1:0] hmean, lmean;

  // sample update
  always_comb begin
    max_d = (max_q == '0) ? sample_i : max_q;
    min_d = (min_q == '0) ? sample_i : min_q;
    if (sample_i > max_d) begin
      max_d = sample_i;
    end
    if (sample_i < min_d) begin
      min_d = sample_i;
    end
    hpeak = (last_q > older_q) && (last_q > sample_i) && (hcnt_q != '1);
    lpeak = (last_q < older_q) && (last_q < sample_i) && (lcnt_q != '1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= SB'(lplt_pkg::BASE_RESET);
      max_q   <= '0;
      min_q   <= '0;
      last_q  <= '0;
      older_q <= '0;
      hsum_q  <= '0;
      lsum_q  <= '0;
      hcnt_q  <= '0;
      lcnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.sample_en) begin
        max_q   <= max_d;
        min_q   <= min_d;
        older_q <= last_q;
        last_q  <= sample_i;
        if (hpeak) begin
          hsum_q <= hsum_q + SW'(last_q);
          hcnt_q <= hcnt_q + 1'b1;
        end
        if (lpeak) begin
          lsum_q <= lsum_q + SW'(last_q);
          lcnt_q <= lcnt_q + 1'b1;
        end
      end else if (cmd_i.report_load) begin
        max_q  <= '0;
        min_q  <= '0;
        hsum_q <= '0;
        lsum_q <= '0;
        hcnt_q <= '0;
        lcnt_q <= '0;
      end
    end
  end

  // restoring division, one quotient bit a cycle per divider
  always_comb begin
    hsh  = {hr_q, hq_q[SW-1]};
    lsh  = {lr_q, lq_q[SW-1]};
    hge  = (hsh >= {1'b0, hc_q});
    lge  = (lsh >= {1'b0, lc_q});
    hr_d = hge ? CB'(hsh - {1'b0, hc_q}) : CB'(hsh);
    lr_d = lge ? CB'(lsh - {1'b0, lc_q}) : CB'(lsh);
    hq_d = {hq_q[SW-2:0], hge};
    lq_d = {lq_q[SW-2:0], lge};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report_load) begin
      hq_q   <= hsum_q;
      lq_q   <= lsum_q;
      hr_q   <= '0;
      lr_q   <= '0;
      hc_q   <= hcnt_q;
      lc_q   <= lcnt_q;
      maxo_q <= {1'b0, max_q} - {1'b0, base_q};
      mino_q <= {1'b0, min_q} - {1'b0, base_q};
    end else if (cmd_i.div_step) begin
      hq_q <= hq_d;
      lq_q <= lq_d;
      hr_q <= hr_d;
      lr_q <= lr_d;
    end
  end

  // empty count gives a zero mean
  assign hmean = (hc_q == '0) ? '0 : hq_q[SB-1:0];
  assign lmean = (lc_q == '0) ? '0 : lq_q[SB-1:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      oah_q  <= {1'b0, hmean} - {1'b0, base_q};
      omax_q <= maxo_q;
      omin_q <= mino_q;
      oal_q  <= {1'b0, lmean} - {1'b0, base_q};
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign avg_high_offset_o = oah_q;
  assign max_offset_o      = omax_q;
  assign min_offset_o      = omin_q;
  assign avg_low_offset_o  = oal_q;

endmodule

// ===== src/local_peak_level_tracker_top.sv =====
// ----------------------------------------------------------------------------
// local_peak_level_tracker_top
// running extremes and local peak averages of a sensor sample stream
// ----------------------------------------------------------------------------
// input words carry req_type_i and sample_i under in_valid_i / in_stall_o;
// a sample word updates max, min, history and the peak sums and gives no
// result. a report word gives one result word on out_valid_o / out_stall_i
// with the four levels minus base_level and clears the sums, counts and
// extremes, keeping the sample history.
// in a report both averages come from two restoring dividers that settle one
// quotient bit a cycle, then the result goes into the output register.
// in_stall_o is high while a report is being worked on.
// a waiting result does not block sample words; a following report finishes
// its division and then holds until the output register is free.
// the user writes base_level through cfg_we_i / cfg_data_i while idle; the
// block does not enforce this. reset clears all levels, sums and counts, sets
// base_level to 1250 and leaves the output empty.
// ----------------------------------------------------------------------------
module local_peak_level_tracker_top #(
  parameter int unsigned SAMPLE_BITS = lplt_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = lplt_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [SAMPLE_BITS-1:0]      cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_BITS:0] avg_high_offset_o,
  output logic signed [SAMPLE_BITS:0] max_offset_o,
  output logic signed [SAMPLE_BITS:0] min_offset_o,
  output logic signed [SAMPLE_BITS:0] avg_low_offset_o
);

  lplt_pkg::cmd_t cmd;
  lplt_pkg::sts_t sts;

  lplt_ctrl #(
    .SUM_BITS (SAMPLE_BITS + COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lplt_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .sample_i          (sample_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .avg_high_offset_o (avg_high_offset_o),
    .max_offset_o      (max_offset_o),
    .min_offset_o      (min_offset_o),
    .avg_low_offset_o  (avg_low_offset_o)
  );

endmodule
